// File: hdl/box_blur_3x3_stream_unit_assert.svh
// Assertion macros for the 3x3 box blur stream unit.
`ifndef BOX_BLUR_3X3_STREAM_UNIT_ASSERT_SVH
`define BOX_BLUR_3X3_STREAM_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Condition holds at every clock edge outside reset.
`define BB3S_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("bb3s assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define BB3S_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bb3s assertion failed");

// Consequent holds in the cycle after the antecedent.
`define BB3S_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bb3s assertion failed");

`else

`define BB3S_ASSERT_ALWAYS(label, clk, rst, expr)
`define BB3S_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BB3S_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hdl/bb3s_pkg.sv
// Shared types and constants for the 3x3 box blur stream unit.
`default_nettype none

package bb3s_pkg;

   // Frame limits
   localparam int BB3S_MAX_WIDTH  = 1024;
   localparam int BB3S_MAX_HEIGHT = 1024;
   localparam int RESET_WIDTH     = 256;
   localparam int RESET_HEIGHT    = 256;

   // Register port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 11;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   // Item kinds on req_tuser
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // Datapath widths
   localparam int PIXEL_W = 8;
   localparam int SUM_W   = 12;   // 9 * 255 = 2295

   // Divide by 9: floor(x * 7282 / 2^16) is exact for x < 32768
   localparam int DIV9_MULT_W = 13;
   localparam int DIV9_MULT   = 7282;
   localparam int DIV9_SHIFT  = 16;
   localparam int PROD_W      = SUM_W + DIV9_MULT_W;

   typedef logic [PIXEL_W-1:0] pixel_type;

   // One line buffer entry: the same column of the two previous rows
   typedef struct packed {
      pixel_type two_above;
      pixel_type above;
   } line_pair_type;

endpackage

`default_nettype wire

// File: hdl/bb3s_line_buffer.sv
// Line buffer memory holding the two previous rows, write-first registered read.
`default_nettype none

module bb3s_line_buffer
   import bb3s_pkg::*;
#(
   parameter int DEPTH = BB3S_MAX_WIDTH
) (
   input  wire logic                       clock,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output line_pair_type                   rd_data,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire line_pair_type              wr_data
);

   line_pair_type mem [DEPTH];
   line_pair_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; a same-cycle write to the same column is forwarded
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/box_blur_3x3_stream_unit.sv
// Top level of the 3x3 box blur: counters, window, mean stage and stream ports.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+---------------------------------------
//   req     | in  | req_tvalid/req_tready  | tdata: pixel_in; tuser: kind
//   rsp     | out | rsp_tvalid/rsp_tready  | tdata: pixel_out; tlast: frame_last
//   csr     | in  | csr_valid/csr_ready    | csr_index: register; csr_data: value
//
// One item is accepted per clock unless backpressure on rsp stalls the pipeline.
// A result passes line buffer read, window and adder tree, then divide-by-9 multiply.
// The line buffer's single read and single write port set the one-item pace.
// Reset is synchronous; it clears counters, window and valid flags, not the memory.
// Backpressure on rsp stalls the pipeline stage by stage; bubbles are squeezed out.
// A register write restarts the frame.
`default_nettype none

`include "box_blur_3x3_stream_unit_assert.svh"

module box_blur_3x3_stream_unit
   import bb3s_pkg::*;
#(
   parameter int MAX_WIDTH  = BB3S_MAX_WIDTH,
   parameter int MAX_HEIGHT = BB3S_MAX_HEIGHT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // input pixels
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,    // [7:0] pixel_in
   input  wire logic                   req_tuser,    // [0] kind
   // results
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [7:0]                  rsp_tdata,    // [7:0] pixel_out
   output logic                        rsp_tlast,
   // register writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);       // column index
   localparam int WW = $clog2(MAX_WIDTH + 1);   // width value
   localparam int HW = $clog2(MAX_HEIGHT + 1);  // height value
   localparam int RW = $clog2(MAX_HEIGHT + 2);  // row counter runs to height + 1
   localparam int W_RST = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
   localparam int H_RST = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

   // ------------------------------------------------------------------
   // Configuration registers, clamped on write
   // ------------------------------------------------------------------
   logic [WW-1:0] w_ff;
   logic [HW-1:0] h_ff;
   logic          csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= WW'(W_RST);
         h_ff <= HW'(H_RST);
      end else if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               if (csr_data == '0) begin
                  w_ff <= WW'(1);
               end else if (32'(csr_data) > MAX_WIDTH) begin
                  w_ff <= WW'(MAX_WIDTH);
               end else begin
                  w_ff <= WW'(csr_data);
               end
            end
            CSR_IMAGE_HEIGHT: begin
               if (csr_data == '0) begin
                  h_ff <= HW'(1);
               end else if (32'(csr_data) > MAX_HEIGHT) begin
                  h_ff <= HW'(MAX_HEIGHT);
               end else begin
                  h_ff <= HW'(csr_data);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline flow control
   // ------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic s1_emit_ff;
   logic out_free, s2_free, s1_adv, s1_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s2_free    = !s2_valid_ff || out_free;
   assign s1_adv     = s1_valid_ff && (!s1_emit_ff || s2_free);
   assign s1_free    = !s1_valid_ff || s1_adv;
   assign req_tready = s1_free;

   // ------------------------------------------------------------------
   // Stream position and per-item decisions
   // ------------------------------------------------------------------
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [WW-1:0] col_step;
   logic [RW-1:0] h_wide;
   logic          accept, pixel_phase, drop, s1_load;
   logic          emit_in, interior_in, last_in;

   assign accept      = req_tvalid && req_tready;
   assign h_wide      = RW'(h_ff);
   assign pixel_phase = row_ff < h_wide;
   // a flush before all pixels are in does nothing
   assign drop        = (req_tuser == KIND_FLUSH) && pixel_phase;
   assign s1_load     = accept && !drop;

   assign emit_in     = (row_ff >= RW'(2)) || ((row_ff == RW'(1)) && (col_ff != '0));
   // column 0 emits the right border pixel of the row before; never interior
   assign interior_in = (col_ff >= CW'(2)) && (row_ff >= RW'(2)) && (row_ff != h_wide);
   assign last_in     = (col_ff == '0) && (row_ff == h_wide + RW'(1));
   assign col_step    = WW'(col_ff) + WW'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_write) begin
         col_in = '0;
         row_in = '0;
      end else if (s1_load) begin
         if (last_in) begin
            col_in = '0;
            row_in = '0;
         end else if (col_step >= w_ff) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = CW'(col_step);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: line buffer read in flight, item registered
   // ------------------------------------------------------------------
   pixel_type     s1_px_ff;
   logic [CW-1:0] s1_addr_ff;
   logic          s1_interior_ff, s1_last_ff;
   line_pair_type lb_rd, lb_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= s1_load;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_px_ff       <= pixel_phase ? req_tdata : '0;
         s1_addr_ff     <= col_ff;
         s1_emit_ff     <= emit_in;
         s1_interior_ff <= interior_in;
         s1_last_ff     <= last_in;
      end
   end

   // rows shift down one place in the buffer as the new pixel goes in
   assign lb_wr.two_above = lb_rd.above;
   assign lb_wr.above     = s1_px_ff;

   bb3s_line_buffer #(
      .DEPTH (MAX_WIDTH)
   ) u_line_buffer (
      .clock   (clock),
      .rd_en   (s1_load),
      .rd_addr (col_ff),
      .rd_data (lb_rd),
      .wr_en   (s1_adv),
      .wr_addr (s1_addr_ff),
      .wr_data (lb_wr)
   );

   // ------------------------------------------------------------------
   // 3x3 window: three columns of three rows, newest column last
   // ------------------------------------------------------------------
   pixel_type          window_ff [9];
   logic [SUM_W-1:0]   sum_in;

   always_ff @(posedge clock) begin
      if (reset || csr_write || (s1_adv && s1_last_ff)) begin
         for (int k = 0; k < 9; k++) begin
            window_ff[k] <= '0;
         end
      end else if (s1_adv) begin
         for (int k = 0; k < 6; k++) begin
            window_ff[k] <= window_ff[k+3];
         end
         window_ff[6] <= lb_rd.two_above;
         window_ff[7] <= lb_rd.above;
         window_ff[8] <= s1_px_ff;
      end
   end

   // neighborhood sum over the window after this item's shift
   assign sum_in = SUM_W'(window_ff[3]) + SUM_W'(window_ff[4]) + SUM_W'(window_ff[5])
                 + SUM_W'(window_ff[6]) + SUM_W'(window_ff[7]) + SUM_W'(window_ff[8])
                 + SUM_W'(lb_rd.two_above) + SUM_W'(lb_rd.above) + SUM_W'(s1_px_ff);

   // ------------------------------------------------------------------
   // Stage 2: sum and pass-through value
   // ------------------------------------------------------------------
   logic [SUM_W-1:0] s2_sum_ff;
   pixel_type        s2_pass_ff;
   logic             s2_interior_ff, s2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_adv && s1_emit_ff;
      end
   end

   // the emitted pixel is the window's center after the shift
   always_ff @(posedge clock) begin
      if (s1_adv && s1_emit_ff) begin
         s2_sum_ff      <= sum_in;
         s2_pass_ff     <= window_ff[7];
         s2_interior_ff <= s1_interior_ff;
         s2_last_ff     <= s1_last_ff;
      end
   end

   // ------------------------------------------------------------------
   // Output register: divide by 9 through a reciprocal multiply
   // ------------------------------------------------------------------
   logic [PROD_W-1:0] prod;
   pixel_type         mean;
   pixel_type         rsp_data_ff;
   logic              rsp_last_ff;

   assign prod = PROD_W'(s2_sum_ff) * PROD_W'(DIV9_MULT);
   assign mean = prod[DIV9_SHIFT +: PIXEL_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s2_valid_ff) begin
         rsp_data_ff <= s2_interior_ff ? mean : s2_pass_ff;
         rsp_last_ff <= s2_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `BB3S_ASSERT_ALWAYS(col_in_range_a, clock, reset, WW'(col_ff) < w_ff)
   `BB3S_ASSERT_IMPLY(last_is_border_a, clock, reset, s1_valid_ff && s1_last_ff, s1_emit_ff && !s1_interior_ff)
   `BB3S_ASSERT_NEXT(csr_restart_a, clock, reset, csr_write, (col_ff == '0) && (row_ff == '0))

endmodule

`default_nettype wire

// File: sim/blur_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the 3x3 box blur stream: a pixel-exact blur predictor and the result check.
package blur_check_pkg;
   import bb3s_pkg::*;

   localparam int WINDOW_TAPS  = 9;    // 3x3 neighborhood, also the divisor of the mean
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      pixel_type pixel;
      logic      frame_last;
   } blur_pixel_type;

   class blur_scoreboard;
      logic [CSR_DATA_W-1:0] width_reg;
      logic [CSR_DATA_W-1:0] height_reg;
      pixel_type             row_above[BB3S_MAX_WIDTH];
      pixel_type             row_two_above[BB3S_MAX_WIDTH];
      pixel_type             window[WINDOW_TAPS];   // three columns of three rows, newest last
      int unsigned           in_col;
      int unsigned           in_row;
      int unsigned           out_index;
      blur_pixel_type        pending_pixels[$];
      int unsigned           mismatch_count;

      function new();
         width_reg  = CSR_DATA_W'(RESET_WIDTH);
         height_reg = CSR_DATA_W'(RESET_HEIGHT);
         foreach (row_above[i]) begin
            row_above[i]     = '0;
            row_two_above[i] = '0;
         end
         mismatch_count = 0;
         restart_frame();
      endfunction

      function void restart_frame();
         foreach (window[k]) window[k] = '0;
         in_col    = 0;
         in_row    = 0;
         out_index = 0;
      endfunction

      // zero acts as one, large values saturate at the given limit
      function int unsigned clamp_dim(logic [CSR_DATA_W-1:0] raw, int unsigned limit);
         if (raw == 0) return 1;
         if (raw > limit) return limit;
         return raw;
      endfunction

      function int unsigned frame_width();
         return clamp_dim(width_reg, BB3S_MAX_WIDTH);
      endfunction

      function int unsigned frame_height();
         return clamp_dim(height_reg, BB3S_MAX_HEIGHT);
      endfunction

      // any register write drops the frame in progress
      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_IMAGE_WIDTH:  width_reg = value;
            CSR_IMAGE_HEIGHT: height_reg = value;
            default: ;
         endcase
         restart_frame();
      endfunction

      // advance the blur by one accepted item; queue the pixel it releases, if any
      function void accept_item(logic kind, pixel_type data);
         int unsigned    w, h, col, row, orow, ocol, sum;
         pixel_type      px, prev_mid, top, mid, value;
         blur_pixel_type res;
         w   = frame_width();
         h   = frame_height();
         col = in_col;
         row = in_row;
         px  = data;

         // flush before the last pixel is dropped; a pixel after it acts as a flush
         if (row < h) begin
            if (kind == KIND_FLUSH) return;
         end else begin
            px = '0;
         end

         // line buffers and window shift
         prev_mid           = window[7];
         top                = row_two_above[col];
         mid                = row_above[col];
         row_two_above[col] = mid;
         row_above[col]     = px;
         for (int k = 0; k < 6; k++) window[k] = window[k + 3];
         window[6] = top;
         window[7] = mid;
         window[8] = px;

         in_col = col + 1;
         if (in_col >= w) begin
            in_col = 0;
            in_row = row + 1;
         end

         // output trails the input by one row and one pixel
         if (row < 2 && !(row == 1 && col >= 1)) return;
         if (col >= 1) begin
            orow  = row - 1;
            ocol  = col - 1;
            value = window[4];
         end else begin
            orow  = row - 2;
            ocol  = w - 1;
            value = prev_mid;
         end

         // interior pixels take the truncated mean, borders pass through
         if (orow != 0 && orow != h - 1 && ocol != 0 && ocol != w - 1) begin
            sum = 0;
            foreach (window[k]) sum += window[k];
            value = pixel_type'(sum / WINDOW_TAPS);
         end

         res.pixel      = value;
         res.frame_last = (out_index >= w * h - 1);
         if (res.frame_last) restart_frame();
         else out_index++;
         pending_pixels.push_back(res);
      endfunction

      function void check_pixel(pixel_type pixel, logic frame_last);
         blur_pixel_type want;
         if (pending_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: unexpected pixel %0d last %0b", $time, pixel, frame_last);
            return;
         end
         want = pending_pixels.pop_front();
         if (pixel !== want.pixel || frame_last !== want.frame_last) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: pixel mismatch: got %0d last %0b, expected %0d last %0b",
                        $time, pixel, frame_last, want.pixel, want.frame_last);
         end
      endfunction

      function int unsigned pending();
         return pending_pixels.size();
      endfunction

      function bit failed();
         return mismatch_count != 0 || pending_pixels.size() != 0;
      endfunction
   endclass

endpackage

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench of the 3x3 box blur stream unit: stimulus, handshakes and final verdict.
module tb_top;
   import bb3s_pkg::*;
   import blur_check_pkg::*;

   // the slowest legal run has every item a long gap and a long stall
   localparam int unsigned TIMEOUT_CYCLES = 600_000;
   localparam int unsigned SETTLE_CYCLES  = 10;     // pipeline depth of three plus margin
   localparam int unsigned RANDOM_ITEMS   = 350;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = '0;
   logic                   req_tuser  = KIND_PIXEL;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   blur_scoreboard sb;
   bit             sender_steady  = 1'b0;
   bit             must_restart   = 1'b0;
   int unsigned    stream_items   = 0;
   int unsigned    cycle_count    = 0;
   int unsigned    ready_hold     = 0;
   int unsigned    ready_roll;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   box_blur_3x3_stream_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // transaction monitor: results are checked before the same edge's input is predicted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_pixel(rsp_tdata, rsp_tlast);
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready) sb.accept_item(req_tuser, req_tdata);
      end
   end

   // result backpressure: short stalls, a few long ones, and long stall-free stretches
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         ready_roll = $urandom_range(99);
         if (ready_roll < 45) begin
            rsp_tready <= 1'b1;
            ready_hold <= $urandom_range(6);
         end else if (ready_roll < 55) begin
            rsp_tready <= 1'b1;
            ready_hold <= $urandom_range(120, 40);
         end else if (ready_roll < 95) begin
            rsp_tready <= 1'b0;
            ready_hold <= $urandom_range(3);
         end else begin
            rsp_tready <= 1'b0;
            ready_hold <= $urandom_range(30, 8);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == TIMEOUT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      if (roll < 98) return $urandom_range(10, 4);
      return $urandom_range(30, 15);
   endfunction

   function automatic pixel_type pick_pixel();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10) return '0;
      if (roll < 20) return '1;
      return pixel_type'($urandom_range(255));
   endfunction

   // small sizes mostly; zero stands for one
   function automatic logic [CSR_DATA_W-1:0] pick_dim();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 5) return '0;
      if (roll < 20) return CSR_DATA_W'($urandom_range(3, 1));
      if (roll < 85) return CSR_DATA_W'($urandom_range(8, 1));
      return CSR_DATA_W'($urandom_range(20, 9));
   endfunction

   task automatic send_item(logic kind, pixel_type px);
      int unsigned gap;
      gap = sender_steady ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // hold the sender until every released pixel is out and the pipeline is quiet
   task automatic pause_sender();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // one frame: pixels then flushes, optionally cut short after cut_at items
   task automatic stream_frame(int unsigned w, int unsigned h, int unsigned cut_at, bit noisy);
      int unsigned sent;
      sent = 0;
      for (int unsigned i = 0; i < w * h; i++) begin
         if (cut_at != 0 && sent >= cut_at) return;
         if (noisy && $urandom_range(99) < 4) send_item(KIND_FLUSH, pick_pixel());
         send_item(KIND_PIXEL, pick_pixel());
         sent++;
         stream_items++;
         if ($urandom_range(999) < 3) pause_sender();
      end
      for (int unsigned i = 0; i <= w; i++) begin
         if (cut_at != 0 && sent >= cut_at) return;
         if (noisy && $urandom_range(99) < 20) send_item(KIND_PIXEL, pick_pixel());
         else send_item(KIND_FLUSH, pick_pixel());
         sent++;
         stream_items++;
      end
   endtask

   // random geometry, then a few frames; a cut frame forces a restart next time
   task automatic random_phase();
      int unsigned           roll, frames, total, cut;
      logic [CSR_DATA_W-1:0] new_width, new_height;
      roll       = $urandom_range(99);
      new_width  = pick_dim();
      new_height = pick_dim();
      if (must_restart || roll < 70) begin
         roll = $urandom_range(99);
         if (roll < 30) begin
            csr_write(CSR_IMAGE_WIDTH, new_width);
            csr_write(CSR_IMAGE_HEIGHT, new_height);
         end else if (roll < 60) begin
            csr_write(CSR_IMAGE_HEIGHT, new_height);
            csr_write(CSR_IMAGE_WIDTH, new_width);
         end else if (roll < 80) begin
            csr_write(CSR_IMAGE_WIDTH, new_width);
         end else begin
            csr_write(CSR_IMAGE_HEIGHT, new_height);
         end
         must_restart = 1'b0;
      end
      sender_steady = ($urandom_range(99) < 15);
      frames        = $urandom_range(3, 1);
      for (int unsigned f = 0; f < frames; f++) begin
         total = sb.frame_width() * sb.frame_height() + sb.frame_width() + 1;
         cut   = ($urandom_range(99) < 8) ? $urandom_range(total - 1, 1) : 0;
         stream_frame(sb.frame_width(), sb.frame_height(), cut, 1'b1);
         if (cut != 0) begin
            must_restart = 1'b1;
            break;
         end
         // a flush at the start of the next frame is dropped
         if ($urandom_range(99) < 10) send_item(KIND_FLUSH, pick_pixel());
      end
      pause_sender();
      sender_steady = 1'b0;
   endtask

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // width left at its reset value, height zero acts as one row; cut after the row wraps
      csr_write(CSR_IMAGE_HEIGHT, '0);
      stream_frame(RESET_WIDTH, 1, RESET_WIDTH + 14, 1'b1);
      pause_sender();

      // 3x3 frame at full scale; center sum 2294 truncates to 254
      csr_write(CSR_IMAGE_WIDTH, 11'd3);
      csr_write(CSR_IMAGE_HEIGHT, 11'd3);
      for (int i = 0; i < 9; i++) begin
         if (i == 4) send_item(KIND_FLUSH, 8'h00);   // dropped: frame still taking pixels
         send_item(KIND_PIXEL, (i == 4) ? 8'd254 : 8'd255);
      end
      send_item(KIND_FLUSH, 8'hFF);
      send_item(KIND_PIXEL, 8'h5A);                  // acts as a flush
      send_item(KIND_FLUSH, 8'h00);
      send_item(KIND_FLUSH, 8'h00);
      pause_sender();

      // single-pixel frame, zero width acts as one
      csr_write(CSR_IMAGE_WIDTH, '0);
      csr_write(CSR_IMAGE_HEIGHT, 11'd1);
      send_item(KIND_PIXEL, 8'h00);
      send_item(KIND_FLUSH, 8'h00);
      send_item(KIND_FLUSH, 8'hFF);
      pause_sender();

      // widest rows: width saturates, frame abandoned early in its second row
      csr_write(CSR_IMAGE_WIDTH, '1);
      csr_write(CSR_IMAGE_HEIGHT, 11'd2);
      stream_frame(BB3S_MAX_WIDTH, 2, BB3S_MAX_WIDTH + 40, 1'b0);
      pause_sender();

      // random geometries and content
      stream_items = 0;
      while (stream_items < RANDOM_ITEMS) random_phase();

      repeat (20) @(posedge clock);
      if (!sb.failed()) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+hdl
hdl/bb3s_pkg.sv
hdl/bb3s_line_buffer.sv
hdl/box_blur_3x3_stream_unit.sv
sim/blur_scoreboard_pkg.sv
sim/tb_top.sv
